/* hw/rtl/lphm_pkg.sv */
`timescale 1ns / 1ps

package lphm_pkg;

    localparam int KEY_W           = 8;
    localparam int VALUE_W         = 32;
    localparam int KEY_SPAN        = 1 << KEY_W;
    localparam int TABLE_SLOTS_DEF = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PS_IDLE,
        PS_READ,
        PS_CHECK,
        PS_DONE
    } probe_state_t;

    // one slot as it sits in the ram
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] read_value;
        status_t                   status;
    } result_t;

endpackage

/* hw/rtl/lphm_ifs.sv */
`timescale 1ns / 1ps

interface lphm_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [7:0]         key;
    logic signed [31:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface lphm_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] read_value;
    logic [1:0]         status;

    modport source (output valid, output found, output read_value, output status, input ready);
    modport sink   (input valid, input found, input read_value, input status, output ready);
endinterface

/* hw/rtl/lphm_slot_ram.sv */
`timescale 1ns / 1ps

module lphm_slot_ram #(
    parameter int TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    output lphm_pkg::slot_t                rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    input  lphm_pkg::slot_t                wr_data
);
    import lphm_pkg::*;

    slot_t slot_mem [TABLE_SLOTS];
    slot_t rd_data_reg;

    // one write port and one registered read port; read data appears the cycle after rd_en
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/lphm_probe.sv */
`timescale 1ns / 1ps

module lphm_probe #(
    parameter int TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_operation,
    input  logic [7:0]                     in_key,
    input  logic signed [31:0]             in_value,
    output logic                           result_valid,
    input  logic                           result_ready,
    output lphm_pkg::result_t              result,
    output logic                           rd_en,
    output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    input  lphm_pkg::slot_t                rd_data,
    output logic                           wr_en,
    output logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    output lphm_pkg::slot_t                wr_data
);
    import lphm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef logic [IDX_W-1:0] home_tbl_t [KEY_SPAN];

    // home slot of every key, worked out at elaboration
    function automatic home_tbl_t build_home();
        home_tbl_t t;
        for (int i = 0; i < KEY_SPAN; i++)
        begin
            t[i] = IDX_W'(i % TABLE_SLOTS);
        end
        return t;
    endfunction

    localparam home_tbl_t HOME_TBL = build_home();

    probe_state_t              state_reg, state_next;
    op_t                       op_reg, op_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic [TABLE_SLOTS-1:0]    valid_reg, valid_next;
    result_t                   res_reg, res_next;

    logic slot_vld;
    logic key_hit;
    logic pass_done;
    logic accept;

    assign accept    = in_valid && (state_reg == PS_IDLE);
    assign slot_vld  = valid_reg[pos_reg];
    assign key_hit   = slot_vld && (rd_data.key == key_reg);
    assign pass_done = (cnt_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op_t'(in_operation) == OP_CLEAR) ? PS_DONE : PS_READ;
                end
            end
            PS_READ:
            begin
                state_next = PS_CHECK;
            end
            PS_CHECK:
            begin
                if (!slot_vld || key_hit || pass_done)
                begin
                    state_next = PS_DONE;
                end
                else
                begin
                    state_next = PS_READ;
                end
            end
            PS_DONE:
            begin
                if (result_ready)
                begin
                    state_next = PS_IDLE;
                end
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == PS_IDLE);
        result_valid = (state_reg == PS_DONE);
        rd_en        = (state_reg == PS_READ);
        rd_addr      = pos_reg;
        wr_en        = (state_reg == PS_CHECK) && (op_reg == OP_INSERT) &&
                       (key_hit || !slot_vld);
        wr_addr      = pos_reg;
        wr_data      = '{key: key_reg, value: value_reg};
        result       = res_reg;
    end

    always_comb
    begin
        op_next    = op_reg;
        key_next   = key_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        res_next   = res_reg;

        if (accept)
        begin
            op_next    = op_t'(in_operation);
            key_next   = in_key;
            value_next = in_value;
            pos_next   = HOME_TBL[in_key];
            cnt_next   = '0;
            res_next   = '{found: 1'b0, read_value: '0, status: ST_OK};
            if (op_t'(in_operation) == OP_CLEAR)
            begin
                valid_next = '0;
            end
        end
        else if (state_reg == PS_CHECK)
        begin
            if (key_hit)
            begin
                res_next.found = 1'b1;
                if (op_reg == OP_ERASE)
                begin
                    valid_next[pos_reg] = 1'b0;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    res_next.read_value = rd_data.value;
                end
            end
            else if (!slot_vld)
            begin
                // empty slot ends the chain
                if (op_reg == OP_INSERT)
                begin
                    valid_next[pos_reg] = 1'b1;
                end
                else
                begin
                    res_next.status = ST_ABSENT;
                end
            end
            else if (pass_done)
            begin
                res_next.status = (op_reg == OP_INSERT) ? ST_FULL : ST_ABSENT;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                pos_next = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

endmodule

/* hw/rtl/linear_probe_hash_map_core.sv */
`timescale 1ns / 1ps

// open-addressed map from 8-bit keys to 32-bit signed values over TABLE_SLOTS slots, with
// linear probing from slot key mod TABLE_SLOTS; each cmd transaction is an insert, erase,
// lookup or clear and yields exactly one rsp transaction (found, read_value, status).
// keys and values live in a single-port-read, single-port-write ram with a registered read
// port; valid marks sit in flip-flops, so reset and clear empty the table at once and
// no clearing pass is needed. an operation holds the block through accept, then one ram
// read plus one compare per probed slot, then result hand-off; a clear goes from accept
// straight to hand-off, and the worst case probes all TABLE_SLOTS slots. the per-slot
// read-then-compare round trip through the ram sets how long an operation takes.
// the result lands in an output register, so the next cmd transaction is taken while the
// previous rsp transaction still waits. erase clears only the valid mark and keeps no
// tombstone, so keys placed past an erased slot may later read as absent.

module linear_probe_hash_map_core #(
    parameter int TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lphm_cmd_if.sink   cmd,
    lphm_rsp_if.source rsp
);
    import lphm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    // probe sequencer <-> slot ram
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_t            rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;

    // sequencer result, handed to the output register
    logic    result_valid;
    logic    result_ready;
    result_t result;

    // output register
    logic    rsp_valid_reg, rsp_valid_next;
    result_t rsp_data_reg, rsp_data_next;

    lphm_slot_ram #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // no forwarding needed: a write happens in the compare cycle and no read of the written
    // slot comes before the write has landed
    lphm_probe #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_probe (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd.valid),
        .in_ready     (cmd.ready),
        .in_operation (cmd.operation),
        .in_key       (cmd.key),
        .in_value     (cmd.value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // output register takes a new result when empty or being drained this cycle
    assign result_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (result_valid && result_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = rsp_data_reg.found;
    assign rsp.read_value = rsp_data_reg.read_value;
    assign rsp.status     = rsp_data_reg.status;

    // one operation at a time: the cycle after a cmd transaction the sequencer is busy
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("cmd accepted while previous operation still probing");

    // a full report never comes with a hit
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> !rsp.found)
        else $error("table full reported for a key that was found");

    // a nonzero read value only comes from a successful lookup
    a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.read_value != '0) |-> rsp.found && (rsp.status == ST_OK))
        else $error("read value returned without a hit");

    // a result waits in the sequencer only while the output register is held
    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> rsp_valid_reg && !rsp.ready)
        else $error("result stalled with free output register");

endmodule
